FILE: design/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types, widths and codes for the matrix multiply / transpose block.
// ----------------------------------------------------------------------------
package mmt_pkg;

  // largest matrix side held in each element store
  localparam int MAX_DIM = 16;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int RES_W   = 36;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CAP_W   = $clog2(MAX_DIM + 1);
  localparam int SEL_W   = (DIM_W > IDX_W) ? DIM_W : IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = PROD_W + DIM_W;
  localparam int ACC_W   = (SUM_W > RES_W) ? SUM_W : RES_W;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_A  = 3'd0,
    FN_WR_B  = 3'd1,
    FN_RD_P  = 3'd2,
    FN_RD_AT = 3'd3,
    FN_RD_BT = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_PUT
  } ctrl_state_e;

  // one read slot handed from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic pass;    // transpose read: multiply by one
    logic pass_b;  // transpose read takes its operand from the b store
  } mmt_issue_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [SEL_W-1:0] r,
                                                  input logic [SEL_W-1:0] c);
    elem_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic [CAP_W-1:0] cap_dim(input logic [CFG_W-1:0] d);
    if (int'(d) > MAX_DIM) begin
      cap_dim = CAP_W'(MAX_DIM);
    end else begin
      cap_dim = CAP_W'(d);
    end
  endfunction

endpackage

FILE: design/mmt_req_if.sv
// ----------------------------------------------------------------------------
// mmt_req_if
// Request channel: element writes and element reads.
// ----------------------------------------------------------------------------
interface mmt_req_if;
  import mmt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [ELEM_W-1:0] value;

  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

FILE: design/mmt_rsp_if.sv
// ----------------------------------------------------------------------------
// mmt_rsp_if
// Response channel: one read result per read request.
// ----------------------------------------------------------------------------
interface mmt_rsp_if;
  import mmt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

FILE: design/matrix_multiply_transpose.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transpose
// Two 16-bit element stores, product and transpose reads through one MAC.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         word
//  req_i     in   valid / ready     func, row, col, value
//  rsp_o     out  valid / ready     result (36-bit signed)
//  cfg       in   cfg_we_i          cfg_idx_i, cfg_wdata_i (5 bits)
//
//  writes give no word; ready stays high for the next word
//  a product read walks n = inner_dim element pairs, one element pair
//  per cycle through the single multiply-accumulate unit and both ram read ports
//  one item in flight; the output register frees the request side while
//  a result waits, a full output register with no ready stalls the sequencer
//  reset clears control and sets every dimension to 16; stores are not cleared
module matrix_multiply_transpose (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mmt_pkg::CFG_W-1:0]       cfg_wdata_i,
  mmt_req_if.sink                         req_i,
  mmt_rsp_if.source                       rsp_o
);
  import mmt_pkg::*;

  logic                     a_we, b_we, a_re, b_re;
  logic [ADDR_W-1:0]        waddr, a_raddr, b_raddr;
  logic [ELEM_W-1:0]        wdata, a_rdata, b_rdata;
  mmt_issue_t               issue;
  logic signed [ACC_W-1:0]  acc;
  logic                     done, put, zero, out_free;
  logic                     out_valid_q;
  logic signed [RES_W-1:0]  result_q;

  mmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_func_i  (req_i.func),
    .req_row_i   (req_i.row),
    .req_col_i   (req_i.col),
    .req_value_i (req_i.value),
    .a_we_o      (a_we),
    .b_we_o      (b_we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .a_re_o      (a_re),
    .b_re_o      (b_re),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .issue_o     (issue),
    .done_i      (done),
    .out_free_i  (out_free),
    .put_o       (put),
    .zero_o      (zero)
  );

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mmt_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .a_rdata_i (a_rdata),
    .b_rdata_i (b_rdata),
    .acc_o     (acc),
    .done_o    (done)
  );

  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      result_q <= zero ? '0 : acc[RES_W-1:0];
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = result_q;

  // a result only enters the output register when it is free
  a_put_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put |-> out_free)
    else $error("result loaded over a pending word");

  // the mac never finishes while the sequencer takes new requests
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !req_i.ready)
    else $error("mac done while sequencer idle");

  // a new output word always comes from a sequencer load
  a_rise_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(put))
    else $error("output valid without a load");

endmodule

FILE: design/mmt_ram.sv
// ----------------------------------------------------------------------------
// mmt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mmt_mac.sv
// ----------------------------------------------------------------------------
// mmt_mac
// Multiply-accumulate unit: registered product, then full-width running sum.
// ----------------------------------------------------------------------------
module mmt_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mmt_pkg::mmt_issue_t              issue_i,
  input  logic signed [mmt_pkg::ELEM_W-1:0] a_rdata_i,
  input  logic signed [mmt_pkg::ELEM_W-1:0] b_rdata_i,
  output logic signed [mmt_pkg::ACC_W-1:0]  acc_o,
  output logic                             done_o
);
  import mmt_pkg::*;

  mmt_issue_t               s1_q, s2_q;
  logic signed [ELEM_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_base;
  logic                     done_q;

  // s1 lines up with the registered ram output
  always_comb begin
    op_a   = s1_q.pass_b ? b_rdata_i : a_rdata_i;
    op_b   = s1_q.pass ? ELEM_W'(signed'(1)) : b_rdata_i;
    prod_d = op_a * op_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= issue_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid & s2_q.last;
    end
  end

  assign acc_base = s2_q.first ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.valid) begin
      acc_q <= acc_base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

FILE: design/mmt_ctrl.sv
// ----------------------------------------------------------------------------
// mmt_ctrl
// Sequencer: dimension registers, store writes, read address walk.
// ----------------------------------------------------------------------------
module mmt_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mmt_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic [mmt_pkg::FUNC_W-1:0]          req_func_i,
  input  logic [mmt_pkg::IDX_W-1:0]           req_row_i,
  input  logic [mmt_pkg::IDX_W-1:0]           req_col_i,
  input  logic [mmt_pkg::ELEM_W-1:0]          req_value_i,
  output logic                                a_we_o,
  output logic                                b_we_o,
  output logic [mmt_pkg::ADDR_W-1:0]          waddr_o,
  output logic [mmt_pkg::ELEM_W-1:0]          wdata_o,
  output logic                                a_re_o,
  output logic                                b_re_o,
  output logic [mmt_pkg::ADDR_W-1:0]          a_raddr_o,
  output logic [mmt_pkg::ADDR_W-1:0]          b_raddr_o,
  output mmt_pkg::mmt_issue_t                 issue_o,
  input  logic                                done_i,
  input  logic                                out_free_i,
  output logic                                put_o,
  output logic                                zero_o
);
  import mmt_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CFG_W-1:0] rows_q, inner_q, cols_q;
  logic [CAP_W-1:0] m_dim, n_dim, p_dim;
  logic [DIM_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] row_q, col_q;
  func_e            fn_q, fn_d, req_fn;
  logic             zero_q, zero_d;
  logic             accept, in_store, k_last;

  assign m_dim  = cap_dim(rows_q);
  assign n_dim  = cap_dim(inner_q);
  assign p_dim  = cap_dim(cols_q);
  assign req_fn = func_e'(req_func_i);
  assign accept = req_valid_i & req_ready_o;
  assign k_last = (int'(k_q) == int'(n_dim) - 1);
  assign in_store = (int'(req_row_i) < MAX_DIM) && (int'(req_col_i) < MAX_DIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ROWS_A:    rows_q  <= cfg_wdata_i;
        CFG_INNER_DIM: inner_q <= cfg_wdata_i;
        CFG_COLS_B:    cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // store writes go straight through while idle
  assign waddr_o = elem_addr(SEL_W'(req_row_i), SEL_W'(req_col_i));
  assign wdata_o = req_value_i;
  assign a_we_o  = accept && (req_fn == FN_WR_A) && in_store;
  assign b_we_o  = accept && (req_fn == FN_WR_B) && in_store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      fn_q    <= FN_RD_P;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      fn_q    <= fn_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= req_row_i;
      col_q <= req_col_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    fn_d        = fn_q;
    zero_d      = zero_q;
    req_ready_o = 1'b0;
    a_re_o      = 1'b0;
    b_re_o      = 1'b0;
    a_raddr_o   = '0;
    b_raddr_o   = '0;
    issue_o     = '0;
    put_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        k_d         = '0;
        if (req_valid_i) begin
          fn_d = req_fn;
          case (req_fn)
            FN_RD_P: begin
              zero_d  = !((int'(req_row_i) < int'(m_dim)) &&
                          (int'(req_col_i) < int'(p_dim))) || (n_dim == '0);
              state_d = zero_d ? S_PUT : S_ISSUE;
            end
            FN_RD_AT: begin
              zero_d  = !((int'(req_row_i) < int'(n_dim)) &&
                          (int'(req_col_i) < int'(m_dim)));
              state_d = zero_d ? S_PUT : S_ISSUE;
            end
            FN_RD_BT: begin
              zero_d  = !((int'(req_row_i) < int'(p_dim)) &&
                          (int'(req_col_i) < int'(n_dim)));
              state_d = zero_d ? S_PUT : S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        issue_o.valid = 1'b1;
        issue_o.first = (k_q == '0);
        case (fn_q)
          FN_RD_P: begin
            a_re_o        = 1'b1;
            b_re_o        = 1'b1;
            a_raddr_o     = elem_addr(SEL_W'(row_q), SEL_W'(k_q));
            b_raddr_o     = elem_addr(SEL_W'(k_q), SEL_W'(col_q));
            issue_o.last  = k_last;
            k_d           = k_q + DIM_W'(1);
            if (k_last) begin
              state_d = S_WAIT;
            end
          end
          FN_RD_AT: begin
            a_re_o       = 1'b1;
            a_raddr_o    = elem_addr(SEL_W'(col_q), SEL_W'(row_q));
            issue_o.last = 1'b1;
            issue_o.pass = 1'b1;
            state_d      = S_WAIT;
          end
          FN_RD_BT: begin
            b_re_o         = 1'b1;
            b_raddr_o      = elem_addr(SEL_W'(col_q), SEL_W'(row_q));
            issue_o.last   = 1'b1;
            issue_o.pass   = 1'b1;
            issue_o.pass_b = 1'b1;
            state_d        = S_WAIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WAIT: begin
        if (done_i) begin
          if (out_free_i) begin
            put_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (out_free_i) begin
          put_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign zero_o = zero_q;

endmodule
